@@ sv/mcs_pkg.sv @@
// shared constants, field widths and sequencer states of the max clique search
`default_nettype none
package mcs_pkg;

  // fixed field widths
  localparam int unsigned MCS_ROW_IDX_W  = 5;
  localparam int unsigned MCS_ROW_BITS_W = 32;
  localparam int unsigned MCS_NV_W       = 6;
  localparam int unsigned MCS_SIZE_W     = 6;

  // default graph capacity and reset vertex count
  localparam int unsigned MCS_MAX_VERTICES = 32;
  localparam logic [MCS_NV_W-1:0] MCS_NV_RESET = 6'd32;

  // search sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_DECIDE,
    S_POP,
    S_DONE
  } mcs_state_t;

endpackage
`default_nettype wire

@@ sv/mcs_channels.sv @@
// valid/ready channel interfaces for row input, result output and configuration
`default_nettype none
interface mcs_in_if import mcs_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [MCS_ROW_IDX_W-1:0]  row_index;
  logic [MCS_ROW_BITS_W-1:0] row_bits;
  logic                      last_row;
  modport source (output valid, row_index, row_bits, last_row, input ready);
  modport sink   (input valid, row_index, row_bits, last_row, output ready);
endinterface

interface mcs_out_if import mcs_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [MCS_SIZE_W-1:0] clique_size;
  modport source (output valid, clique_size, input ready);
  modport sink   (input valid, clique_size, output ready);
endinterface

interface mcs_cfg_if import mcs_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [MCS_NV_W-1:0] num_vertices;
  modport source (output valid, num_vertices, input ready);
  modport sink   (input valid, num_vertices, output ready);
endinterface
`default_nettype wire

@@ sv/max_clique_size_search.sv @@
// Row loading: one word per cycle; in ready whenever no search runs.
// Search after the last row: each candidate step passes the evaluate and decide states through
// one shared popcount/priority/mask unit, each backtrack adds a pop state for the stack memory read,
// and a done state posts the result; the total is data dependent.
// No new row is accepted during a search. The result waits in an output register.
// Synchronous active-low reset: idle, no result pending, num_vertices 32; memories not cleared.
`default_nettype none
module max_clique_size_search import mcs_pkg::*; #(
  parameter int unsigned MAX_VERTICES = MCS_MAX_VERTICES
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  mcs_in_if.sink      in_ch,
  mcs_out_if.source   out_ch,
  mcs_cfg_if.sink     cfg_ch
);

  localparam int unsigned AW = $clog2(MAX_VERTICES);
  localparam int unsigned DW = $clog2(MAX_VERTICES + 1);

  typedef logic [MAX_VERTICES-1:0] vset_t;

  // bit count of a vertex set
  function automatic logic [DW-1:0] count_set(input vset_t s);
    logic [DW-1:0] n;
    n = '0;
    for (int i = 0; i < int'(MAX_VERTICES); i++) begin
      n = n + DW'(s[i]);
    end
    return n;
  endfunction

  // index of the lowest member
  function automatic logic [AW-1:0] lowest_member(input vset_t s);
    logic [AW-1:0] v;
    v = '0;
    for (int i = int'(MAX_VERTICES) - 1; i >= 0; i--) begin
      if (s[i]) begin
        v = AW'(i);
      end
    end
    return v;
  endfunction

  // input row widened or cut to the graph capacity
  function automatic vset_t fit_row(input logic [MCS_ROW_BITS_W-1:0] b);
    vset_t r;
    r = '0;
    for (int i = 0; i < int'(MAX_VERTICES); i++) begin
      if (i < int'(MCS_ROW_BITS_W)) begin
        r[i] = b[i];
      end
    end
    return r;
  endfunction

  // vertices in use
  function automatic vset_t used_mask(input logic [MCS_NV_W-1:0] nv);
    vset_t m;
    for (int i = 0; i < int'(MAX_VERTICES); i++) begin
      m[i] = (i < int'(nv));
    end
    return m;
  endfunction

  mcs_state_t state_r, state_nxt;

  logic [MCS_NV_W-1:0] num_vertices_r;
  logic [DW-1:0]       depth_r, depth_nxt;
  logic [DW-1:0]       best_r, best_nxt;
  logic [DW-1:0]       pop_r, pop_nxt;
  logic [AW-1:0]       v_r, v_nxt;
  vset_t               cur_r, cur_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [MCS_SIZE_W-1:0] out_size_r, out_size_nxt;

  // memories: adjacency rows and saved candidate sets of the levels below the top
  vset_t adj_mem [MAX_VERTICES];
  vset_t stk_mem [MAX_VERTICES];
  vset_t adj_q, stk_q;

  logic        in_acc;
  logic        stk_we, stk_re;
  logic [AW-1:0] stk_addr;
  vset_t       all_mask, vbit, next_set;
  logic        prune;

  assign in_ch.ready     = (state_r == S_IDLE);
  assign in_acc          = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready    = 1'b1;
  assign out_ch.valid    = out_valid_r;
  assign out_ch.clique_size = out_size_r;

  assign all_mask = used_mask(num_vertices_r);
  assign vbit     = vset_t'(1) << v_r;
  assign next_set = cur_r & adj_q & ~vbit & all_mask;
  assign prune    = (cur_r == '0) ||
                    (({1'b0, depth_r} + {1'b0, pop_r}) <= {1'b0, best_r});

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_vertices_r <= MCS_NV_RESET;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      num_vertices_r <= cfg_ch.num_vertices;
    end
  end

  // adjacency memory: row write on accept, registered read of the chosen vertex
  always_ff @(posedge clk) begin
    if (in_acc && (int'(in_ch.row_index) < int'(MAX_VERTICES))) begin
      adj_mem[AW'(in_ch.row_index)] <= fit_row(in_ch.row_bits);
    end
    if (state_r == S_EVAL) begin
      adj_q <= adj_mem[v_nxt];
    end
  end

  // candidate stack memory
  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[stk_addr] <= cur_r;
    end
    if (stk_re) begin
      stk_q <= stk_mem[stk_addr];
    end
  end

  // state and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      depth_r     <= '0;
      best_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      depth_r     <= depth_nxt;
      best_r      <= best_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    pop_r      <= pop_nxt;
    v_r        <= v_nxt;
    out_size_r <= out_size_nxt;
  end

  // sequencer: next state and shared evaluation unit
  always_comb begin
    state_nxt     = state_r;
    depth_nxt     = depth_r;
    best_nxt      = best_r;
    cur_nxt       = cur_r;
    pop_nxt       = pop_r;
    v_nxt         = v_r;
    out_valid_nxt = out_valid_r;
    out_size_nxt  = out_size_r;
    stk_we        = 1'b0;
    stk_re        = 1'b0;
    stk_addr      = AW'(depth_r);

    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc && in_ch.last_row) begin
          cur_nxt   = all_mask;
          depth_nxt = '0;
          best_nxt  = '0;
          state_nxt = S_EVAL;
        end
      end
      // count candidates, pick the lowest and fetch its row
      S_EVAL: begin
        pop_nxt   = count_set(cur_r);
        v_nxt     = lowest_member(cur_r);
        state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        if (prune) begin
          if (depth_r == '0) begin
            state_nxt = S_DONE;
          end else begin
            depth_nxt = depth_r - DW'(1);
            stk_addr  = AW'(depth_r - DW'(1));
            stk_re    = 1'b1;
            state_nxt = S_POP;
          end
        end else if (next_set == '0) begin
          // maximal clique reached here: record and drop the vertex
          if ((depth_r + DW'(1)) > best_r) begin
            best_nxt = depth_r + DW'(1);
          end
          cur_nxt   = cur_r & ~vbit;
          state_nxt = S_EVAL;
        end else begin
          // descend; a level can hold at most MAX_VERTICES minus depth candidates,
          // so the depth stays below MAX_VERTICES
          stk_we    = 1'b1;
          cur_nxt   = next_set;
          depth_nxt = depth_r + DW'(1);
          state_nxt = S_EVAL;
        end
      end
      // parent set back from the stack, its chosen vertex dropped
      S_POP: begin
        cur_nxt   = stk_q & (stk_q - vset_t'(1));
        state_nxt = S_EVAL;
      end
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_size_nxt  = MCS_SIZE_W'(best_r);
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // checks
  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(depth_r) < int'(MAX_VERTICES))
    else $error("search depth reached graph capacity");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result posted outside the done step");

  a_best_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) |-> (int'(best_r) <= int'(MAX_VERTICES)))
    else $error("best size above graph capacity");

endmodule
`default_nettype wire

@@ tb/tb.sv @@
// testbench for max_clique_size_search: directed and random graphs checked against a branch-and-bound predictor
module tb import mcs_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RANDOM_WORDS = 1550;
  localparam int unsigned STALL_LIMIT  = 400000;

  // expected clique sizes and a private copy of the graph
  class clique_scoreboard;
    bit [MCS_ROW_BITS_W-1:0] adj_rows [MCS_MAX_VERTICES];
    bit [MCS_NV_W-1:0]       vertex_count;
    bit [MCS_SIZE_W-1:0]     sizes_due [$];
    int unsigned             errors;

    function new();
      vertex_count = MCS_NV_RESET;
      errors = 0;
    endfunction

    function void set_vertices(bit [MCS_NV_W-1:0] count);
      vertex_count = count;
    endfunction

    // depth-first search, lowest candidate first, pruned on size bound
    function bit [MCS_SIZE_W-1:0] largest_clique();
      bit [31:0]   level [0:MCS_MAX_VERTICES];
      bit [31:0]   span, cand, nxt, vbit;
      int unsigned n, depth, best, v;
      n = (vertex_count > MCS_MAX_VERTICES) ? MCS_MAX_VERTICES : vertex_count;
      span = (n >= 32) ? 32'hFFFF_FFFF : ((32'd1 << n) - 32'd1);
      best = 0;
      depth = 0;
      level[0] = span;
      forever begin
        cand = level[depth];
        if (cand == 0 || depth + $countones(cand) <= best) begin
          if (depth == 0) break;
          depth--;
          // drop the vertex taken at the parent level
          level[depth] = level[depth] & (level[depth] - 32'd1);
        end else begin
          v = 0;
          while (!cand[v]) v++;
          vbit = 32'd1 << v;
          nxt = cand & adj_rows[v] & ~vbit & span;
          if (nxt == 0 || depth + 1 > MCS_MAX_VERTICES) begin
            if (depth + 1 > best) best = depth + 1;
            level[depth] = cand & ~vbit;
          end else begin
            level[depth+1] = nxt;
            depth++;
          end
        end
      end
      return best[MCS_SIZE_W-1:0];
    endfunction

    function void note_row(bit [MCS_ROW_IDX_W-1:0] idx, bit [MCS_ROW_BITS_W-1:0] bits,
                           bit last);
      adj_rows[idx] = bits;
      if (last) sizes_due.push_back(largest_clique());
    endfunction

    function void check_size(bit [MCS_SIZE_W-1:0] got);
      bit [MCS_SIZE_W-1:0] want;
      if (sizes_due.size() == 0) begin
        $error("clique_size: no word expected, actual %0d", got);
        errors++;
      end else begin
        want = sizes_due.pop_front();
        if (want != got) begin
          $error("clique_size: expected %0d, actual %0d", want, got);
          errors++;
        end
      end
    endfunction

    function int unsigned pending();
      return sizes_due.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;

  mcs_in_if  in_if();
  mcs_out_if out_if();
  mcs_cfg_if cfg_if();

  max_clique_size_search u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  clique_scoreboard    sb;
  int unsigned         idle_pct;
  int unsigned         stall_pct;
  bit [MCS_NV_W-1:0]   cur_nv;
  bit [31:0]           rows_seen;
  int unsigned         words_in;
  int unsigned         stall_cycles;

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // receiver backpressure
  always @(negedge clk) begin
    out_if.ready <= ($urandom_range(99) >= stall_pct);
  end

  // result checking
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) sb.check_size(out_if.clique_size);
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready) || !rst_n) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // one row word, valid held high until accepted
  task automatic send_row(input bit [MCS_ROW_IDX_W-1:0] idx,
                          input bit [MCS_ROW_BITS_W-1:0] bits, input bit last);
    while ($urandom_range(99) < idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.row_index <= idx;
    in_if.row_bits  <= bits;
    in_if.last_row  <= last;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    sb.note_row(idx, bits, last);
    rows_seen[idx] = 1'b1;
    words_in++;
    @(negedge clk);
  endtask

  // register write once the search pipeline has drained
  task automatic set_vertices(input bit [MCS_NV_W-1:0] count);
    in_if.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_if.valid        <= 1'b1;
    cfg_if.num_vertices <= count;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    sb.set_vertices(count);
    cur_nv = count;
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  // vertex counts weighted toward small graphs, extremes included
  function automatic bit [MCS_NV_W-1:0] pick_vertex_count();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 4) return 6'd0;
    if (r < 8) return 6'd1;
    if (r < 12) return 6'd32;
    if (r < 14) return 6'd33;
    if (r < 16) return 6'd63;
    if (r < 70) return 6'($urandom_range(10, 2));
    if (r < 90) return 6'($urandom_range(20, 11));
    return 6'($urandom_range(32, 21));
  endfunction

  // one graph: symmetric rows in random order, some noise and broken sets
  task automatic run_graph();
    bit [31:0]   g [32];
    int          perm [32];
    bit [31:0]   span;
    int          n, p, i, j, t, cnt;
    n = (cur_nv > MCS_MAX_VERTICES) ? MCS_MAX_VERTICES : cur_nv;
    if (n == 0) begin
      send_row(5'($urandom_range(31)), $urandom, 1'b1);
      return;
    end
    span = (n >= 32) ? 32'hFFFF_FFFF : ((32'd1 << n) - 32'd1);
    if (n > 20) begin
      case ($urandom_range(3))
        0: p = 0;
        1: p = 25;
        2: p = 50;
        default: p = 100;
      endcase
    end else begin
      p = $urandom_range(100);
    end
    // noise above the graph, random diagonal, then symmetric edges
    for (i = 0; i < n; i++) begin
      g[i] = $urandom & ~span;
      g[i][i] = $urandom_range(1);
    end
    for (i = 1; i < n; i++) begin
      for (j = 0; j < i; j++) begin
        if ($urandom_range(99) < p) begin
          g[i][j] = 1'b1;
          g[j][i] = 1'b1;
        end
      end
    end
    if ($urandom_range(9) == 0) begin
      i = $urandom_range(n - 1);
      j = $urandom_range(n - 1);
      g[i][j] = ~g[i][j];
    end
    for (i = 0; i < n; i++) perm[i] = i;
    for (i = n - 1; i > 0; i--) begin
      j = $urandom_range(i);
      t = perm[i];
      perm[i] = perm[j];
      perm[j] = t;
    end
    // partial reload only once every row of the graph has been written
    cnt = n;
    if ((rows_seen & span) == span && $urandom_range(9) == 0) cnt = $urandom_range(n, 1);
    for (i = 0; i < cnt; i++) begin
      if ($urandom_range(99) < 5) send_row(5'($urandom_range(31)), $urandom, 1'b0);
      send_row(5'(perm[i]), g[perm[i]], (i == cnt - 1));
    end
  endtask

  initial begin
    sb = new();
    idle_pct = 0;
    stall_pct = 0;
    cur_nv = MCS_NV_RESET;
    rows_seen = '0;
    words_in = 0;
    stall_cycles = 0;
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.row_index = '0;
    in_if.row_bits = '0;
    in_if.last_row = 1'b0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.num_vertices = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // zero vertices
    set_vertices(6'd0);
    send_row(5'd0, 32'hFFFF_FFFF, 1'b1);
    // single vertex with only a self-loop
    set_vertices(6'd1);
    send_row(5'd0, 32'h0000_0001, 1'b1);
    // asymmetric rows: vertex 0 sees 1 and 2, they see only 0
    set_vertices(6'd3);
    send_row(5'd0, 32'h0000_0006, 1'b0);
    send_row(5'd1, 32'h0000_0001, 1'b0);
    send_row(5'd2, 32'h0000_0001, 1'b1);
    // last word on a row outside the graph
    set_vertices(6'd2);
    send_row(5'd0, 32'h0000_0002, 1'b0);
    send_row(5'd1, 32'h0000_0001, 1'b0);
    send_row(5'd31, 32'hA5A5_5A5A, 1'b1);
    // all ones: bits beyond the graph and diagonal set
    set_vertices(6'd4);
    send_row(5'd0, 32'hFFFF_FFFF, 1'b0);
    send_row(5'd1, 32'hFFFF_FFFF, 1'b0);
    send_row(5'd2, 32'hFFFF_FFFF, 1'b0);
    send_row(5'd3, 32'hFFFF_FFFF, 1'b1);
    // no edges at all
    send_row(5'd2, 32'h0000_0000, 1'b0);
    send_row(5'd0, 32'h0000_0000, 1'b0);
    send_row(5'd3, 32'h0000_0000, 1'b0);
    send_row(5'd1, 32'h0000_0000, 1'b1);

    // random graphs across idling phases
    words_in = 0;
    while (words_in < RANDOM_WORDS) begin
      case (words_in * 4 / RANDOM_WORDS)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 87; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 87; end
        default: begin idle_pct = 10; stall_pct = 10; end
      endcase
      if ($urandom_range(1) == 0) set_vertices(pick_vertex_count());
      run_graph();
    end

    in_if.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
